[rtl/osmw_pkg.sv]
// Shared types and constants for the oil sensor min/max and warning monitor.
package osmw_pkg;

    // Number of display modes the mode button cycles through.
    localparam int unsigned MODE_COUNT = 4;
    localparam int unsigned MODE_CNT_W = $clog2(MODE_COUNT + 1) + 1;

    // Field widths.
    localparam int unsigned TEMP_W  = 10;
    localparam int unsigned PRESS_W = 8;
    localparam int unsigned MODE_W  = 2;

    // Register map: register index taken from the word address.
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_TEMP_LIMIT  = 1'b0;
    localparam logic REG_PRESS_LIMIT = 1'b1;

    // Register reset values.
    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST  = 10'sd250;
    localparam logic [PRESS_W-1:0]       PRESS_LIMIT_RST = 8'd15;

    // Display mode forced by a warning.
    localparam logic [MODE_W-1:0] MODE_COMBINED = 2'd0;

    // One sample tick.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_reading;
        logic [PRESS_W-1:0]       press_reading;
        logic                     mode_button_down;
        logic                     reset_button_down;
    } sample_t;

    // One result.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_min;
        logic signed [TEMP_W-1:0] temp_max;
        logic [PRESS_W-1:0]       pressure_min;
        logic [PRESS_W-1:0]       pressure_max;
        logic                     warning;
        logic                     engine_running;
        logic [MODE_W-1:0]        display_mode;
    } result_t;

    // Warning limits from the configuration port.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_limit;
        logic [PRESS_W-1:0]       press_limit;
    } limits_t;

endpackage

[rtl/osmw_core.sv]
// Monitor state and its per-sample update: extremes, engine latch, warning, mode.
module osmw_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  osmw_pkg::sample_t sample,
    input  osmw_pkg::limits_t limits,
    output osmw_pkg::result_t result
);

    logic signed [osmw_pkg::TEMP_W-1:0] temp_lowest_reg, temp_lowest_next;
    logic signed [osmw_pkg::TEMP_W-1:0] temp_highest_reg, temp_highest_next;
    logic [osmw_pkg::PRESS_W-1:0]       press_lowest_reg, press_lowest_next;
    logic [osmw_pkg::PRESS_W-1:0]       press_highest_reg, press_highest_next;
    logic                               first_pending_reg;
    logic                               started_reg, started_next;
    logic                               warn_reg, warn_next;
    logic [osmw_pkg::MODE_W-1:0]        mode_reg, mode_next;
    logic                               mode_held_reg, mode_held_next;
    logic                               reset_held_reg, reset_held_next;

    logic signed [osmw_pkg::TEMP_W-1:0] t_lo_base, t_hi_base;
    logic [osmw_pkg::PRESS_W-1:0]       p_lo_base, p_hi_base;
    logic [osmw_pkg::MODE_W-1:0]        mode_forced;
    logic [osmw_pkg::MODE_CNT_W-1:0]    mode_inc;
    logic                               reseed;

    // Next-state logic for one sample, in the order the monitor defines.
    always_comb
    begin
        // The first sample seeds the extremes.
        t_lo_base = first_pending_reg ? sample.temp_reading : temp_lowest_reg;
        t_hi_base = first_pending_reg ? sample.temp_reading : temp_highest_reg;
        p_lo_base = first_pending_reg ? sample.press_reading : press_lowest_reg;
        p_hi_base = first_pending_reg ? sample.press_reading : press_highest_reg;

        // Releasing the reset button reseeds everything from this sample.
        reseed          = reset_held_reg && !sample.reset_button_down;
        reset_held_next = sample.reset_button_down;

        if (reseed)
        begin
            temp_lowest_next   = sample.temp_reading;
            temp_highest_next  = sample.temp_reading;
            press_lowest_next  = sample.press_reading;
            press_highest_next = sample.press_reading;
        end
        else
        begin
            temp_lowest_next   = (sample.temp_reading < t_lo_base) ? sample.temp_reading
                                                                   : t_lo_base;
            temp_highest_next  = (sample.temp_reading > t_hi_base) ? sample.temp_reading
                                                                   : t_hi_base;
            press_lowest_next  = (sample.press_reading < p_lo_base) ? sample.press_reading
                                                                    : p_lo_base;
            press_highest_next = (sample.press_reading > p_hi_base) ? sample.press_reading
                                                                    : p_hi_base;
        end

        // Engine start latches once pressure reaches its limit.
        started_next = started_reg || (sample.press_reading >= limits.press_limit);

        // The warning is only evaluated once the engine is running.
        if (started_next)
        begin
            warn_next = (sample.temp_reading >= limits.temp_limit)
                        || (sample.press_reading < limits.press_limit);
        end
        else
        begin
            warn_next = warn_reg;
        end
        mode_forced = (started_next && warn_next) ? osmw_pkg::MODE_COMBINED : mode_reg;

        // Releasing the mode button advances the mode, wrapping at the mode count.
        mode_inc = {{(osmw_pkg::MODE_CNT_W - osmw_pkg::MODE_W){1'b0}}, mode_forced}
                   + osmw_pkg::MODE_CNT_W'(1);
        if (mode_inc >= osmw_pkg::MODE_CNT_W'(osmw_pkg::MODE_COUNT))
        begin
            mode_inc = '0;
        end
        mode_held_next = sample.mode_button_down;
        if (mode_held_reg && !sample.mode_button_down)
        begin
            mode_next = mode_inc[osmw_pkg::MODE_W-1:0];
        end
        else
        begin
            mode_next = mode_forced;
        end
    end

    // State registers, updated once per sample taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_lowest_reg   <= '0;
            temp_highest_reg  <= '0;
            press_lowest_reg  <= '0;
            press_highest_reg <= '0;
            first_pending_reg <= 1'b1;
            started_reg       <= 1'b0;
            warn_reg          <= 1'b0;
            mode_reg          <= osmw_pkg::MODE_COMBINED;
            mode_held_reg     <= 1'b0;
            reset_held_reg    <= 1'b0;
        end
        else if (update)
        begin
            temp_lowest_reg   <= temp_lowest_next;
            temp_highest_reg  <= temp_highest_next;
            press_lowest_reg  <= press_lowest_next;
            press_highest_reg <= press_highest_next;
            first_pending_reg <= 1'b0;
            started_reg       <= started_next;
            warn_reg          <= warn_next;
            mode_reg          <= mode_next;
            mode_held_reg     <= mode_held_next;
            reset_held_reg    <= reset_held_next;
        end
    end

    // The result carries the state after this sample.
    always_comb
    begin
        result.temp_min       = temp_lowest_next;
        result.temp_max       = temp_highest_next;
        result.pressure_min   = press_lowest_next;
        result.pressure_max   = press_highest_next;
        result.warning        = warn_next;
        result.engine_running = started_next;
        result.display_mode   = mode_next;
    end

    // Once seeded, the minimum never exceeds the maximum on either channel.
    a_temp_order: assert property (@(posedge clk) disable iff (!rst_n)
        !first_pending_reg |-> (temp_lowest_reg <= temp_highest_reg))
        else $error("temperature minimum above maximum");
    a_press_order: assert property (@(posedge clk) disable iff (!rst_n)
        !first_pending_reg |-> (press_lowest_reg <= press_highest_reg))
        else $error("pressure minimum above maximum");
    a_warn_started: assert property (@(posedge clk) disable iff (!rst_n)
        warn_reg |-> started_reg)
        else $error("warning set before engine start");

endmodule

[rtl/oil_sensor_minmax_warn_monitor_top.sv]
// Top level of the oil sensor min/max and warning monitor: stream ports and registers.
//
// Usage:
//   Samples enter on the s_axis channel: s_tdata carries temperature and pressure,
//   s_tuser the two button levels. Each sample gives exactly one result on the
//   m_axis channel: the four running extremes in m_tdata, and the warning,
//   engine-running flag and display mode in m_tuser.
//   A sample is held in the input register and then in the result register before
//   its result is offered.
//   Throughput is one sample per cycle while results are taken; the state update is a
//   single shallow pass of compares and selects between the input and result registers.
//   When the receiver stalls, the result register holds its transaction and the
//   input register takes one more sample; s_tready then drops until the result
//   is taken.
//   Reset clears both stages, restores the limit registers to 250 and 15,
//   clears the engine latch, warning and mode, and arms seeding of the extremes
//   by the next sample.
//   The APB port writes the two limits at byte addresses 0 and 4; they should be
//   written only while no sample is in flight.
module oil_sensor_minmax_warn_monitor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [osmw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Sample stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // temp_reading[9:0], press_reading[17:10],
                                                  // zeros
    input  logic [1:0]                  s_tuser,  // mode_button_down[0], reset_button_down[1]
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,  // temp_min[9:0], temp_max[19:10],
                                                  // pressure_min[27:20], pressure_max[35:28],
                                                  // zeros
    output logic [3:0]                  m_tuser   // warning[0], engine_running[1],
                                                  // display_mode[3:2]
);

    osmw_pkg::limits_t limits_reg;
    osmw_pkg::sample_t in_data_reg;
    osmw_pkg::result_t out_data_reg;
    osmw_pkg::result_t core_result;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.temp_limit  <= osmw_pkg::TEMP_LIMIT_RST;
            limits_reg.press_limit <= osmw_pkg::PRESS_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                osmw_pkg::REG_TEMP_LIMIT:
                    limits_reg.temp_limit <= pwdata[osmw_pkg::TEMP_W-1:0];
                osmw_pkg::REG_PRESS_LIMIT:
                    limits_reg.press_limit <= pwdata[osmw_pkg::PRESS_W-1:0];
                default:
                    limits_reg <= limits_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            osmw_pkg::REG_TEMP_LIMIT:
                prdata = {{(32 - osmw_pkg::TEMP_W){limits_reg.temp_limit[osmw_pkg::TEMP_W-1]}},
                          limits_reg.temp_limit};
            osmw_pkg::REG_PRESS_LIMIT:
                prdata = {{(32 - osmw_pkg::PRESS_W){1'b0}}, limits_reg.press_limit};
            default:
                prdata = '0;
        endcase
    end

    // The held sample moves on whenever the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg.temp_reading      <= s_tdata[9:0];
            in_data_reg.press_reading     <= s_tdata[17:10];
            in_data_reg.mode_button_down  <= s_tuser[0];
            in_data_reg.reset_button_down <= s_tuser[1];
        end
    end

    // Monitor state and update logic.
    osmw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .sample (in_data_reg),
        .limits (limits_reg),
        .result (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.pressure_max, out_data_reg.pressure_min,
                       out_data_reg.temp_max, out_data_reg.temp_min};
    assign m_tuser  = {out_data_reg.display_mode, out_data_reg.engine_running,
                       out_data_reg.warning};

    // A warning always comes with a running engine, and with the combined display
    // when the mode button was still held on that sample.
    a_warn_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.warning) |-> out_data_reg.engine_running)
        else $error("warning without engine running");
    a_warn_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.warning && $past(in_data_reg.mode_button_down))
        |-> (out_data_reg.display_mode == osmw_pkg::MODE_COMBINED || $past(!advance)))
        else $error("warning did not force the combined display");
    // An empty input stage always takes a sample.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");
    // A sample moved on always lands in the result register.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sample lost between stages");

endmodule

[tb/sv/oil_sensor_minmax_warn_monitor_top_test.sv]
// Self-checking testbench for the oil sensor min/max and warning monitor.
`timescale 1ns / 100ps

module oil_sensor_minmax_warn_monitor_top_test;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int CYCLE_LIMIT = 200000;

    // Clock, reset and every block input start at known values.
    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [osmw_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [23:0]                 s_tdata  = '0;  // temp_reading[9:0], press_reading[17:10],
                                                 // zeros
    logic [1:0]                  s_tuser  = '0;  // mode_button_down[0], reset_button_down[1]
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [39:0]                 m_tdata;        // temp_min[9:0], temp_max[19:10],
                                                 // pressure_min[27:20], pressure_max[35:28],
                                                 // zeros
    logic [3:0]                  m_tuser;        // warning[0], engine_running[1],
                                                 // display_mode[3:2]

    // Samples waiting for the driver, and gauge readings due from the block.
    osmw_pkg::sample_t samples_pending[$];
    osmw_pkg::result_t gauge_readings_due[$];

    int samples_queued   = 0;
    int samples_accepted = 0;
    int mismatch_count   = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 16;
    int recv_idle_pct    = 58;
    bit sender_hold      = 1'b0;

    // Own copy of the limits and the gauge state.
    logic signed [osmw_pkg::TEMP_W-1:0] limit_temp     = osmw_pkg::TEMP_LIMIT_RST;
    logic [osmw_pkg::PRESS_W-1:0]       limit_press    = osmw_pkg::PRESS_LIMIT_RST;
    logic signed [osmw_pkg::TEMP_W-1:0] temp_low_now   = '0;
    logic signed [osmw_pkg::TEMP_W-1:0] temp_high_now  = '0;
    logic [osmw_pkg::PRESS_W-1:0]       press_low_now  = '0;
    logic [osmw_pkg::PRESS_W-1:0]       press_high_now = '0;
    bit                                 seed_pending   = 1'b1;
    bit                                 engine_latched = 1'b0;
    bit                                 warn_now       = 1'b0;
    logic [osmw_pkg::MODE_W-1:0]        mode_now       = osmw_pkg::MODE_COMBINED;
    bit                                 mode_btn_held  = 1'b0;
    bit                                 reset_btn_held = 1'b0;

    oil_sensor_minmax_warn_monitor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter with a hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Works out the gauge reading that one sample tick produces.
    function automatic osmw_pkg::result_t predict_gauge_reading(input osmw_pkg::sample_t smp);
        osmw_pkg::result_t r;
        int unsigned       nxt;
        if (seed_pending)
        begin
            temp_low_now   = smp.temp_reading;
            temp_high_now  = smp.temp_reading;
            press_low_now  = smp.press_reading;
            press_high_now = smp.press_reading;
            seed_pending   = 1'b0;
        end
        if (smp.temp_reading < temp_low_now)
            temp_low_now = smp.temp_reading;
        if (smp.temp_reading > temp_high_now)
            temp_high_now = smp.temp_reading;
        if (smp.press_reading < press_low_now)
            press_low_now = smp.press_reading;
        if (smp.press_reading > press_high_now)
            press_high_now = smp.press_reading;

        if (smp.press_reading >= limit_press)
            engine_latched = 1'b1;

        // Warnings only count once the engine has started; a warning forces combined mode.
        if (engine_latched)
        begin
            warn_now = (smp.temp_reading >= limit_temp) || (smp.press_reading < limit_press);
            if (warn_now)
                mode_now = osmw_pkg::MODE_COMBINED;
        end

        // Buttons act on release.
        if (smp.mode_button_down)
            mode_btn_held = 1'b1;
        else if (mode_btn_held)
        begin
            mode_btn_held = 1'b0;
            nxt = int'(mode_now) + 1;
            if (nxt >= osmw_pkg::MODE_COUNT)
                nxt = 0;
            mode_now = nxt[osmw_pkg::MODE_W-1:0];
        end

        if (smp.reset_button_down)
            reset_btn_held = 1'b1;
        else if (reset_btn_held)
        begin
            reset_btn_held = 1'b0;
            temp_low_now   = smp.temp_reading;
            temp_high_now  = smp.temp_reading;
            press_low_now  = smp.press_reading;
            press_high_now = smp.press_reading;
        end

        r.temp_min       = temp_low_now;
        r.temp_max       = temp_high_now;
        r.pressure_min   = press_low_now;
        r.pressure_max   = press_high_now;
        r.warning        = warn_now;
        r.engine_running = engine_latched;
        r.display_mode   = mode_now;
        return r;
    endfunction

    // Sample driver: predicts on each accepted transaction and loads the next sample.
    always @(posedge clk)
    begin
        osmw_pkg::sample_t smp;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                smp.temp_reading      = s_tdata[9:0];
                smp.press_reading     = s_tdata[17:10];
                smp.mode_button_down  = s_tuser[0];
                smp.reset_button_down = s_tuser[1];
                gauge_readings_due.push_back(predict_gauge_reading(smp));
                samples_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (samples_pending.size() > 0 && !sender_hold
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    smp = samples_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, smp.press_reading, smp.temp_reading};
                    s_tuser  <= {smp.reset_button_down, smp.mode_button_down};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted transaction with the oldest reading due.
    always @(posedge clk)
    begin
        osmw_pkg::result_t got;
        osmw_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                got.temp_min       = m_tdata[9:0];
                got.temp_max       = m_tdata[19:10];
                got.pressure_min   = m_tdata[27:20];
                got.pressure_max   = m_tdata[35:28];
                got.warning        = m_tuser[0];
                got.engine_running = m_tuser[1];
                got.display_mode   = m_tuser[3:2];
                if (gauge_readings_due.size() == 0)
                    report_mismatch("result arrived with no reading due");
                else
                begin
                    want = gauge_readings_due.pop_front();
                    if (got.temp_min !== want.temp_min)
                        report_mismatch($sformatf("temp_min got %0d, expected %0d",
                                                  got.temp_min, want.temp_min));
                    if (got.temp_max !== want.temp_max)
                        report_mismatch($sformatf("temp_max got %0d, expected %0d",
                                                  got.temp_max, want.temp_max));
                    if (got.pressure_min !== want.pressure_min)
                        report_mismatch($sformatf("pressure_min got %0d, expected %0d",
                                                  got.pressure_min, want.pressure_min));
                    if (got.pressure_max !== want.pressure_max)
                        report_mismatch($sformatf("pressure_max got %0d, expected %0d",
                                                  got.pressure_max, want.pressure_max));
                    if (got.warning !== want.warning)
                        report_mismatch($sformatf("warning got %0b, expected %0b",
                                                  got.warning, want.warning));
                    if (got.engine_running !== want.engine_running)
                        report_mismatch($sformatf("engine_running got %0b, expected %0b",
                                                  got.engine_running, want.engine_running));
                    if (got.display_mode !== want.display_mode)
                        report_mismatch($sformatf("display_mode got %0d, expected %0d",
                                                  got.display_mode, want.display_mode));
                end
            end
        end
    end

    // Queues one sample tick for the driver.
    task automatic add_sample(input int t, input int p, input bit mode_btn, input bit rst_btn);
        osmw_pkg::sample_t smp;
        smp.temp_reading      = t[osmw_pkg::TEMP_W-1:0];
        smp.press_reading     = p[osmw_pkg::PRESS_W-1:0];
        smp.mode_button_down  = mode_btn;
        smp.reset_button_down = rst_btn;
        samples_pending.push_back(smp);
        samples_queued++;
    endtask

    // Random tick: readings often close to the current limits, buttons pressed at random.
    task automatic add_random_sample();
        int t;
        int p;
        if ($urandom_range(0, 2) == 0)
        begin
            t = int'(limit_temp) + $urandom_range(0, 6) - 3;
            t = (t < -128) ? -128 : ((t > 511) ? 511 : t);
        end
        else
            t = $urandom_range(0, 639) - 128;
        if ($urandom_range(0, 2) == 0)
        begin
            p = int'(limit_press) + $urandom_range(0, 6) - 3;
            p = (p < 0) ? 0 : ((p > 255) ? 255 : p);
        end
        else
            p = $urandom_range(0, 255);
        add_sample(t, p, $urandom_range(0, 99) < 35, $urandom_range(0, 99) < 15);
    endtask

    // Writes one limit register over APB, then reads it back.
    task automatic write_limit(input logic reg_sel, input int value);
        logic [31:0] wdata;
        wdata = $urandom();
        if (reg_sel == osmw_pkg::REG_TEMP_LIMIT)
            wdata[osmw_pkg::TEMP_W-1:0] = value[osmw_pkg::TEMP_W-1:0];
        else
            wdata[osmw_pkg::PRESS_W-1:0] = value[osmw_pkg::PRESS_W-1:0];

        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == osmw_pkg::REG_TEMP_LIMIT)
            limit_temp = wdata[osmw_pkg::TEMP_W-1:0];
        else
            limit_press = wdata[osmw_pkg::PRESS_W-1:0];

        // Read-back transaction.
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == osmw_pkg::REG_TEMP_LIMIT
            && prdata[osmw_pkg::TEMP_W-1:0] !== limit_temp)
            report_mismatch($sformatf("temp_warn_limit read %0h, expected %0h",
                                      prdata[osmw_pkg::TEMP_W-1:0], limit_temp));
        if (reg_sel == osmw_pkg::REG_PRESS_LIMIT
            && prdata[osmw_pkg::PRESS_W-1:0] !== limit_press)
            report_mismatch($sformatf("pressure_warn_limit read %0h, expected %0h",
                                      prdata[osmw_pkg::PRESS_W-1:0], limit_press));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued sample is in and every reading has come out.
    task automatic wait_drained();
        @(negedge clk);
        while (samples_accepted != samples_queued || gauge_readings_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus sequencing: directed ticks, then random phases under varied limits.
    initial
    begin
        int ph;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, -128);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, 0);
                    end
                    2:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, 511);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, 255);
                    end
                    4:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, 0);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, 128);
                    end
                    6:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, 511);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, 0);
                    end
                    7:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, -128);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, 255);
                    end
                    default:
                    begin
                        write_limit(osmw_pkg::REG_TEMP_LIMIT, $urandom_range(0, 639) - 128);
                        write_limit(osmw_pkg::REG_PRESS_LIMIT, $urandom_range(0, 255));
                    end
                endcase
            end

            // The receiver idles most first, then the sender, then neither.
            if (ph < 3)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 58;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (ph == 0)
            begin
                // First sample seeds the extremes; engine not yet started.
                add_sample(100, 5, 1, 0);
                add_sample(-128, 0, 1, 0);
                // Mode release before engine start is not forced back.
                add_sample(20, 3, 0, 0);
                add_sample(0, 14, 0, 1);
                // Reset release reseeds from the current readings.
                add_sample(5, 10, 0, 0);
                // Pressure exactly at the limit latches the engine; hot oil warns.
                add_sample(300, 15, 0, 0);
                add_sample(249, 15, 0, 0);
                add_sample(250, 200, 0, 0);
                add_sample(511, 255, 0, 0);
                add_sample(100, 14, 0, 0);
                // Mode walks round and wraps to combined.
                add_sample(100, 100, 1, 0);
                add_sample(100, 100, 0, 0);
                add_sample(100, 100, 1, 0);
                add_sample(100, 100, 0, 0);
                add_sample(100, 100, 1, 0);
                add_sample(100, 100, 0, 0);
                add_sample(100, 100, 1, 0);
                add_sample(100, 100, 0, 0);
                // Release during a warning: forced to combined, then advanced.
                add_sample(260, 100, 1, 0);
                add_sample(260, 100, 0, 1);
                add_sample(-50, 0, 0, 0);
                // Both buttons released on the same tick.
                add_sample(100, 100, 1, 1);
                add_sample(-1, 40, 0, 0);
            end

            repeat (PHASE_ITEMS) add_random_sample();

            // Once, the sender holds off mid-phase until the block has drained.
            if (ph == 3)
            begin
                @(negedge clk);
                while (samples_accepted < samples_queued - PHASE_ITEMS / 2)
                    @(negedge clk);
                sender_hold = 1'b1;
                while (gauge_readings_due.size() != 0 || s_tvalid)
                    @(negedge clk);
                sender_hold = 1'b0;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
